### hdl/bchd_pkg.sv
// Shared types and constants for the button click / hold detector.
// Holds the per-button mode and event types, command codes and register indexes.
// No dependencies.
package bchd_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int LEVELS_W    = 3;
    localparam int CMD_W       = 3;
    localparam int NOW_W       = 32;

    // Per-button mode; MODE_WAIT is never entered but is handled as a release wait.
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PRESSED = 2'd1,
        MODE_HELD    = 2'd2,
        MODE_WAIT    = 2'd3
    } btn_mode_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CLICK = 2'd1,
        EV_HOLD  = 2'd2
    } btn_ev_t;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0]    DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_W-1:0]    LONG_PRESS_RST = 16'd500;
    localparam logic [CFG_W-1:0]    REPEAT_RST     = 16'd100;
    localparam logic [LEVELS_W-1:0] ACTIVE_RST     = 3'b111;

    // Output command codes.
    localparam logic [CMD_W-1:0] CMD_NONE         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CENTRE_CLICK = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CENTRE_HOLD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LEFT_CLICK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LEFT_HOLD    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RIGHT_CLICK  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RIGHT_HOLD   = 3'd6;

    localparam logic [CMD_W-1:0] CMD_CLICK_CODE [NUM_BUTTONS] =
        '{CMD_CENTRE_CLICK, CMD_LEFT_CLICK, CMD_RIGHT_CLICK};
    localparam logic [CMD_W-1:0] CMD_HOLD_CODE [NUM_BUTTONS] =
        '{CMD_CENTRE_HOLD, CMD_LEFT_HOLD, CMD_RIGHT_HOLD};

endpackage

### hdl/button_click_hold_detector.sv
// Top level of the three-button click / hold detector.
// Depends on bchd_pkg for mode, event and command definitions.
//
// Usage:
// Each beat on the slave stream (s_tvalid/s_tready/s_tdata) is one poll sample:
// a millisecond timestamp and the raw pin levels of the centre, left and right
// buttons. Every sample yields exactly one beat on the master stream carrying a
// command code (0 when nothing happened). Each button runs its own idle /
// pressed / held machine; all three advance on every sample, and when several
// report an event in one sample the centre wins over left, left over right.
// Time differences wrap modulo 2^TIMESTAMP_BITS.
// A sample is captured in the input register; the three machines then evaluate
// it from there and load the result register.
// Throughput is one sample per clock while the receiver accepts results; the only
// serial dependency is the per-button state, which is updated in the same cycle it is read.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready drops only when both are occupied, so no beat is lost.
// Reset clears both pipeline registers, puts every button into idle and loads
// the default thresholds (20, 500 and 100 ms, all buttons active high).
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at the next
// edge and are meant to be issued while the stream is idle.
module button_click_hold_detector
    import bchd_pkg::*;
#(
    parameter int TIMESTAMP_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Sample stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] now_ms, [32] centre_level, [33] left_level, [34] right_level, [39:35] zero
    input  logic [39:0]           s_tdata,
    // Command stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] command, [7:3] zero
    output logic [7:0]            m_tdata,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int TS_W = TIMESTAMP_BITS;

    // Configuration registers.
    logic [CFG_W-1:0]    debounce_reg;
    logic [CFG_W-1:0]    long_press_reg;
    logic [CFG_W-1:0]    repeat_reg;
    logic [LEVELS_W-1:0] active_reg;

    // Input register.
    logic                s1_valid_reg;
    logic [NOW_W-1:0]    s1_now_reg;
    logic [LEVELS_W-1:0] s1_levels_reg;

    // Result register.
    logic                out_valid_reg;
    logic [CMD_W-1:0]    out_cmd_reg;

    // Per-button state.
    btn_mode_t           mode_reg   [NUM_BUTTONS];
    btn_mode_t           mode_next  [NUM_BUTTONS];
    logic [TS_W-1:0]     start_reg  [NUM_BUTTONS];
    logic [TS_W-1:0]     start_next [NUM_BUTTONS];
    logic [TS_W-1:0]     rep_reg    [NUM_BUTTONS];
    logic [TS_W-1:0]     rep_next   [NUM_BUTTONS];

    logic                advance;
    logic [TS_W-1:0]     now_ts;
    logic [LEVELS_W-1:0] pressed;
    logic [TS_W-1:0]     since_start [NUM_BUTTONS];
    logic [TS_W-1:0]     since_rep   [NUM_BUTTONS];
    btn_ev_t             ev          [NUM_BUTTONS];
    logic [CMD_W-1:0]    cmd;

    // The sample in the input register is evaluated when the result register
    // is free or is being emptied in this cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_cmd_reg};

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
            repeat_reg     <= REPEAT_RST;
            active_reg     <= ACTIVE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                REG_REPEAT:     repeat_reg     <= cfg_wdata;
                REG_ACTIVE:     active_reg     <= cfg_wdata[LEVELS_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_now_reg    <= s_tdata[NOW_W-1:0];
            s1_levels_reg <= s_tdata[NOW_W+LEVELS_W-1:NOW_W];
        end
    end

    // ------------------------------------------------------------------
    // Per-button evaluation
    // ------------------------------------------------------------------
    assign now_ts  = TS_W'(s1_now_reg);
    // A button counts as pressed when its pin matches its active level.
    assign pressed = ~(s1_levels_reg ^ active_reg);

    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            since_start[b] = now_ts - start_reg[b];
            since_rep[b]   = now_ts - rep_reg[b];
        end
    end

    // Next-state logic.
    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            mode_next[b]  = mode_reg[b];
            start_next[b] = start_reg[b];
            rep_next[b]   = rep_reg[b];
            unique case (mode_reg[b])
                MODE_IDLE:
                begin
                    if (pressed[b])
                    begin
                        mode_next[b]  = MODE_PRESSED;
                        start_next[b] = now_ts;
                    end
                end
                MODE_PRESSED:
                begin
                    if (!pressed[b])
                    begin
                        mode_next[b] = MODE_IDLE;
                    end
                    else if (since_start[b] >= TS_W'(long_press_reg))
                    begin
                        mode_next[b] = MODE_HELD;
                        rep_next[b]  = now_ts;
                    end
                end
                MODE_HELD:
                begin
                    if (!pressed[b])
                    begin
                        mode_next[b] = MODE_IDLE;
                    end
                    else if (since_rep[b] >= TS_W'(repeat_reg))
                    begin
                        rep_next[b] = now_ts;
                    end
                end
                default:
                begin
                    if (!pressed[b])
                    begin
                        mode_next[b] = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    // Event outputs of the three machines.
    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            ev[b] = EV_NONE;
            unique case (mode_reg[b])
                MODE_IDLE:
                begin
                    ev[b] = EV_NONE;
                end
                MODE_PRESSED:
                begin
                    if (!pressed[b])
                    begin
                        if (since_start[b] >= TS_W'(debounce_reg))
                        begin
                            ev[b] = EV_CLICK;
                        end
                    end
                    else if (since_start[b] >= TS_W'(long_press_reg))
                    begin
                        ev[b] = EV_HOLD;
                    end
                end
                MODE_HELD:
                begin
                    if (pressed[b] && (since_rep[b] >= TS_W'(repeat_reg)))
                    begin
                        ev[b] = EV_HOLD;
                    end
                end
                default:
                begin
                    ev[b] = EV_NONE;
                end
            endcase
        end
    end

    // Priority select: walk from lowest to highest priority so the centre
    // button overrides the others.
    always_comb
    begin
        cmd = CMD_NONE;
        for (int b = NUM_BUTTONS - 1; b >= 0; b--)
        begin
            case (ev[b])
                EV_CLICK: cmd = CMD_CLICK_CODE[b];
                EV_HOLD:  cmd = CMD_HOLD_CODE[b];
                default:  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                mode_reg[b]  <= MODE_IDLE;
                start_reg[b] <= '0;
                rep_reg[b]   <= '0;
            end
        end
        else if (advance)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                mode_reg[b]  <= mode_next[b];
                start_reg[b] <= start_next[b];
                rep_reg[b]   <= rep_next[b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_cmd_reg <= cmd;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A captured sample is always evaluated into the result register.
    a_sample_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("evaluated sample did not reach the result register");

    // The centre button can only report a hold while pressed or held.
    a_centre_hold_source: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd == CMD_CENTRE_HOLD) |->
            (mode_reg[0] == MODE_PRESSED || mode_reg[0] == MODE_HELD))
        else $error("centre hold reported from a wrong mode");

    // A centre click always returns the centre machine to idle.
    a_centre_click_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd == CMD_CENTRE_CLICK) |=> mode_reg[0] == MODE_IDLE)
        else $error("centre click did not return to idle");

    // The wait mode is never entered by any button.
    a_no_wait_mode: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg[0] != MODE_WAIT && mode_reg[1] != MODE_WAIT &&
        mode_reg[2] != MODE_WAIT)
        else $error("button entered the wait mode");

endmodule
